### sv/assert_macros.svh
// Assertion macros used by the RTL top level of the CEC header-match receiver.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define CHMA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Implication from a trigger to a consequence, checked outside reset.
`define CHMA_ASSERT_IMPL(label, trig, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cons)) \
        else $error(msg);

`endif

### sv/chma_pkg.sv
// Package with constants and types of the CEC header-match receiver.
`timescale 1ns / 1ps

package chma_pkg;

    localparam int TIME_BITS_DEFAULT = 32;
    localparam int TS_W              = 32;
    localparam int TS_EXT_W          = 64;
    localparam int ADDR_W            = 4;
    localparam int PHASE_W           = 4;
    localparam int HDR_W             = 9;
    localparam int CFG_IDX_W         = 4;
    localparam int CFG_DATA_W        = 4;

    localparam int START_FALL_MIN = 4300;
    localparam int START_FALL_MAX = 4700;
    localparam int START_RISE_MIN = 3500;
    localparam int START_RISE_MAX = 3900;
    localparam int BIT_FALL_MIN   = 2050;
    localparam int BIT_FALL_MAX   = 2750;
    localparam int ONE_RISE_MIN   = 400;
    localparam int ONE_RISE_MAX   = 800;
    localparam int ZERO_RISE_MIN  = 1300;
    localparam int ZERO_RISE_MAX  = 1700;

    localparam logic [PHASE_W-1:0] PHASE_START = 4'd0;
    localparam logic [PHASE_W-1:0] PHASE_FIRST = 4'd1;
    localparam logic [PHASE_W-1:0] PHASE_EOM   = 4'd9;
    localparam logic [PHASE_W-1:0] PHASE_ACK   = 4'd10;

    localparam logic [CFG_IDX_W-1:0] CFG_MONITOR_ENABLE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS    = 4'd1;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic               awaiting_rise;
    } t_rx_state;

    typedef struct packed {
        t_rx_state state;
        logic      ref_load;
    } t_rx_next;

    typedef struct packed {
        logic               ack_drive;
        logic [PHASE_W-1:0] bit_position;
        logic               window_fail;
    } t_rx_result;

endpackage

### sv/chma_channels.sv
// Handshake channel interfaces for edges, results and configuration writes.
`timescale 1ns / 1ps

interface chma_edge_if;
    logic                      valid;
    logic                      ready;
    logic                      line_level;
    logic [chma_pkg::TS_W-1:0] timestamp_us;

    modport source (output valid, output line_level, output timestamp_us, input ready);
    modport sink   (input valid, input line_level, input timestamp_us, output ready);
endinterface

interface chma_result_if;
    logic                         valid;
    logic                         ready;
    logic                         ack_drive;
    logic [chma_pkg::PHASE_W-1:0] bit_position;
    logic                         window_fail;

    modport source (output valid, output ack_drive, output bit_position,
                    output window_fail, input ready);
    modport sink   (input valid, input ack_drive, input bit_position,
                    input window_fail, output ready);
endinterface

interface chma_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [chma_pkg::CFG_IDX_W-1:0]  index;
    logic [chma_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/chma_step.sv
// Edge evaluation: window checks, header bit match and next receiver state.
`timescale 1ns / 1ps

module chma_step #(
    parameter int TIME_BITS = chma_pkg::TIME_BITS_DEFAULT
) (
    input  logic                           i_enable,
    input  logic [chma_pkg::ADDR_W-1:0]    i_own_address,
    input  chma_pkg::t_rx_state            i_state,
    input  logic [TIME_BITS-1:0]           i_ref_time,
    input  logic                           i_line_level,
    input  logic [TIME_BITS-1:0]           i_ts,
    output chma_pkg::t_rx_next             o_next,
    output chma_pkg::t_rx_result           o_result
);

    logic [TIME_BITS-1:0]               w_dt;
    logic [chma_pkg::HDR_W-1:0]         w_hdr;
    logic [chma_pkg::PHASE_W-1:0]       w_sel;
    logic                               w_hdr_bit;
    logic                               w_start_fall_ok;
    logic                               w_bit_fall_ok;
    logic                               w_start_rise_ok;
    logic                               w_one_rise_ok;
    logic                               w_zero_rise_ok;
    logic [chma_pkg::PHASE_W-1:0]       w_phase;
    logic                               w_await;
    logic                               w_ok;
    logic                               w_ack;
    logic                               w_fail;
    logic                               w_ref_load;

    assign w_dt = i_ts - i_ref_time;

    assign w_start_fall_ok = (w_dt >= TIME_BITS'(chma_pkg::START_FALL_MIN))
                          && (w_dt <= TIME_BITS'(chma_pkg::START_FALL_MAX));
    assign w_bit_fall_ok   = (w_dt >= TIME_BITS'(chma_pkg::BIT_FALL_MIN))
                          && (w_dt <= TIME_BITS'(chma_pkg::BIT_FALL_MAX));
    assign w_start_rise_ok = (w_dt >= TIME_BITS'(chma_pkg::START_RISE_MIN))
                          && (w_dt <= TIME_BITS'(chma_pkg::START_RISE_MAX));
    assign w_one_rise_ok   = (w_dt >= TIME_BITS'(chma_pkg::ONE_RISE_MIN))
                          && (w_dt <= TIME_BITS'(chma_pkg::ONE_RISE_MAX));
    assign w_zero_rise_ok  = (w_dt >= TIME_BITS'(chma_pkg::ZERO_RISE_MIN))
                          && (w_dt <= TIME_BITS'(chma_pkg::ZERO_RISE_MAX));

    // Expected header: initiator, destination, then EOM set.
    assign w_hdr = {i_own_address, i_own_address, 1'b1};

    always_comb begin
        w_phase    = i_state.phase;
        w_await    = i_state.awaiting_rise;
        w_ok       = 1'b0;
        w_ack      = 1'b0;
        w_fail     = 1'b0;
        w_ref_load = 1'b0;
        w_sel      = chma_pkg::PHASE_EOM - w_phase;
        w_hdr_bit  = 1'b0;

        if (i_enable) begin
            if (w_phase > chma_pkg::PHASE_ACK) begin
                w_phase = chma_pkg::PHASE_START;
                w_await = 1'b0;
            end
            w_sel = chma_pkg::PHASE_EOM - w_phase;
            if (w_sel < chma_pkg::PHASE_W'(chma_pkg::HDR_W)) begin
                w_hdr_bit = w_hdr[w_sel];
            end

            if (!w_await) begin
                w_ref_load = 1'b1;
                if (!i_line_level) begin
                    if (w_phase == chma_pkg::PHASE_START) begin
                        w_await = 1'b1;
                    end else if (w_phase == chma_pkg::PHASE_ACK) begin
                        w_ack = 1'b1;
                    end else if ((w_phase == chma_pkg::PHASE_FIRST) ? w_start_fall_ok
                                                                     : w_bit_fall_ok) begin
                        w_await = 1'b1;
                    end else begin
                        w_fail = 1'b1;
                    end
                end
                if (!w_await) begin
                    w_phase = chma_pkg::PHASE_START;
                end
            end else begin
                if (i_line_level) begin
                    if (w_phase == chma_pkg::PHASE_START) begin
                        w_ok = w_start_rise_ok;
                    end else if (w_phase <= chma_pkg::PHASE_EOM) begin
                        w_ok = w_hdr_bit ? w_one_rise_ok : w_zero_rise_ok;
                    end
                end
                if (w_ok) begin
                    w_phase = w_phase + 4'd1;
                    w_await = 1'b0;
                end else begin
                    w_fail     = i_line_level;
                    w_phase    = chma_pkg::PHASE_START;
                    w_await    = 1'b0;
                    w_ref_load = 1'b1;
                end
            end
        end
    end

    assign o_next.state.phase         = w_phase;
    assign o_next.state.awaiting_rise = w_await;
    assign o_next.ref_load            = w_ref_load;
    assign o_result.ack_drive         = w_ack;
    assign o_result.bit_position      = w_phase;
    assign o_result.window_fail       = w_fail;

endmodule

### sv/cec_header_match_ack_top.sv
// Top level of the CEC header-match acknowledge receiver.
// An accepted edge sits in the input register, its result in the result
// register. Throughput: one edge per clock unless the result channel stalls;
// the registers decouple the channels, so an edge is taken while a result waits.
// Reset (synchronous, active low) clears the receiver state, the reference
// time and both configuration registers, and empties both registers.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module cec_header_match_ack_top #(
    parameter int TIME_BITS = chma_pkg::TIME_BITS_DEFAULT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    chma_edge_if.sink            i_edge,
    chma_cfg_if.sink             i_cfg,
    chma_result_if.source        o_result
);

    logic                              r_in_valid;
    logic                              r_in_level;
    logic [chma_pkg::TS_W-1:0]         r_in_ts;
    logic                              r_out_valid;
    chma_pkg::t_rx_result              r_out;
    chma_pkg::t_rx_state               r_state;
    logic [TIME_BITS-1:0]              r_ref_time;
    logic                              r_enable;
    logic [chma_pkg::ADDR_W-1:0]       r_own_address;

    logic                              w_advance;
    logic                              w_in_fire;
    logic                              w_cfg_fire;
    logic [chma_pkg::TS_EXT_W-1:0]     w_ts_ext;
    logic [TIME_BITS-1:0]              w_ts;
    chma_pkg::t_rx_next                n_next;
    chma_pkg::t_rx_result              n_result;

    assign w_advance  = r_in_valid && (!r_out_valid || o_result.ready);
    assign w_in_fire  = i_edge.valid && i_edge.ready;
    assign w_cfg_fire = i_cfg.valid && i_cfg.ready;

    assign i_edge.ready = !r_in_valid || w_advance;
    assign i_cfg.ready  = 1'b1;

    assign w_ts_ext = {{(chma_pkg::TS_EXT_W - chma_pkg::TS_W){1'b0}}, r_in_ts};
    assign w_ts     = w_ts_ext[TIME_BITS-1:0];

    chma_step #(
        .TIME_BITS (TIME_BITS)
    ) u_step (
        .i_enable      (r_enable),
        .i_own_address (r_own_address),
        .i_state       (r_state),
        .i_ref_time    (r_ref_time),
        .i_line_level  (r_in_level),
        .i_ts          (w_ts),
        .o_next        (n_next),
        .o_result      (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_state       <= '0;
            r_ref_time    <= '0;
            r_enable      <= 1'b0;
            r_own_address <= '0;
        end else begin
            if (w_in_fire) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end

            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end

            if (w_advance) begin
                r_state <= n_next.state;
                if (n_next.ref_load) begin
                    r_ref_time <= w_ts;
                end
            end

            if (w_cfg_fire) begin
                case (i_cfg.index)
                    chma_pkg::CFG_MONITOR_ENABLE: begin
                        if (i_cfg.data[0] != r_enable) begin
                            r_state <= '0;
                        end
                        r_enable <= i_cfg.data[0];
                    end
                    chma_pkg::CFG_OWN_ADDRESS: begin
                        r_own_address <= i_cfg.data[chma_pkg::ADDR_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_in_level <= i_edge.line_level;
            r_in_ts    <= i_edge.timestamp_us;
        end
        if (w_advance) begin
            r_out <= n_result;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.ack_drive    = r_out.ack_drive;
    assign o_result.bit_position = r_out.bit_position;
    assign o_result.window_fail  = r_out.window_fail;

    `CHMA_ASSERT(a_phase_range, r_state.phase <= chma_pkg::PHASE_ACK, "header phase out of range")
    `CHMA_ASSERT_IMPL(a_ack_restarts, r_out_valid && r_out.ack_drive, r_out.bit_position == chma_pkg::PHASE_START && !r_out.window_fail, "acknowledge without restart")
    `CHMA_ASSERT_IMPL(a_fail_restarts, r_out_valid && r_out.window_fail, r_out.bit_position == chma_pkg::PHASE_START, "window failure without restart")
    `CHMA_ASSERT_IMPL(a_ack_awaits_fall, w_advance && n_result.ack_drive, !n_next.state.awaiting_rise && n_next.ref_load, "acknowledge left a rise pending")

endmodule
